/* hdl/fspa_pkg.sv */
package fspa_pkg;

    localparam int CFG_W      = 13;
    localparam int OFF_W      = 20;
    localparam int STATUS_W   = 3;
    localparam int SLOT_NUM_W = 8;
    localparam int FREE_W     = 9;

    // restoring divider: one quotient bit per cycle
    localparam int DIV_STEPS = OFF_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0] ENTRY_BYTES_RST = 13'd64;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_RANGE    = 3'd2,
        ST_ALIGN    = 3'd3,
        ST_NOTTAKEN = 3'd4
    } t_status;

    typedef struct packed {
        logic             done;
        logic [OFF_W-1:0] quo;
        logic [CFG_W-1:0] rem;
    } t_div_res;

endpackage

/* hdl/fspa_ram.sv */
module fspa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/fspa_div.sv */
module fspa_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [fspa_pkg::OFF_W-1:0]   i_dividend,
    input  logic [fspa_pkg::CFG_W-1:0]   i_divisor,
    output fspa_pkg::t_div_res           o_res
);
    import fspa_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [OFF_W-1:0] r_quo;
    logic [CFG_W-1:0] r_rem;
    logic [CFG_W-1:0] r_dvs;

    logic [CFG_W:0]   shifted;
    logic             ge;
    logic [CFG_W-1:0] n_rem;

    // divisor is never zero here; caller screens that case
    always_comb begin
        shifted = {r_rem, r_quo[OFF_W-1]};
        ge      = (shifted >= {1'b0, r_dvs});
        n_rem   = ge ? CFG_W'(shifted - {1'b0, r_dvs}) : CFG_W'(shifted);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[OFF_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem;

endmodule

/* hdl/fixed_slot_pool_allocator.sv */
// Pool allocator for SLOTS equal-size slots. A free-slot stack and a taken map live in
// two RAMs with registered reads; every command (cmd 0 allocate, cmd 1 free at a byte
// offset) returns exactly one result with status, slot number, byte offset and the free
// count after the command. After reset the block sweeps both RAMs, one entry per cycle,
// so no command is taken until the sweep is done (configuration writes are taken at
// any time). An allocate's result is loaded into the output register after a stack read
// with offset multiply, then write back. A free's result is loaded after the bit-serial
// divider that splits the offset by entry_bytes, a step to see it finish, a taken-map
// read, and write back; a free whose quotient shows it out of range or whose remainder
// shows it misaligned skips the taken-map read. A free with a zero entry size and an
// allocate on an empty pool go straight to the result state. The next command is
// accepted the cycle after a result is loaded, so the input stays closed from the accept
// until then. One command is in flight at a time; a finished result sits in an output
// register so the next command can be accepted while it waits to be taken. A result that
// finds the output register still full waits in place while the receiver stalls.
module fixed_slot_pool_allocator #(
    parameter int SLOTS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fspa_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic [fspa_pkg::OFF_W-1:0]        i_free_offset,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [fspa_pkg::STATUS_W-1:0]     o_status,
    output logic [fspa_pkg::SLOT_NUM_W-1:0]   o_slot_number,
    output logic [fspa_pkg::OFF_W-1:0]        o_slot_offset,
    output logic [fspa_pkg::FREE_W-1:0]       o_free_slots
);
    import fspa_pkg::*;

    localparam int SW     = $clog2(SLOTS);
    localparam int FCW    = $clog2(SLOTS + 1);
    localparam int PROD_W = SW + CFG_W;

    typedef enum logic [5:0] {
        S_INIT = 6'b000001,
        S_IDLE = 6'b000010,
        S_ARD  = 6'b000100,
        S_DIV  = 6'b001000,
        S_TRD  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [FCW-1:0]     r_fc, n_fc;
    logic [CFG_W-1:0]   r_eb;
    logic [SW-1:0]      r_init_idx;
    logic               r_out_valid;

    logic               r_cmd;
    logic [OFF_W-1:0]   r_off;
    logic [SW-1:0]      r_slot;
    logic [PROD_W-1:0]  r_prod;
    t_status            r_status;
    logic               r_ok;

    t_status            r_out_status;
    logic [SLOT_NUM_W-1:0] r_out_slot;
    logic [OFF_W-1:0]   r_out_offset;
    logic [FREE_W-1:0]  r_out_free;

    logic               stack_we;
    logic [SW-1:0]      stack_waddr, stack_wdata, stack_raddr, stack_rdata;
    logic               taken_we, taken_wdata, taken_rdata;
    logic [SW-1:0]      taken_waddr, taken_raddr;

    logic               div_start;
    t_div_res           div_res;

    logic               accept;
    logic               out_load;

    fspa_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (stack_waddr),
        .i_wdata (stack_wdata),
        .i_raddr (stack_raddr),
        .o_rdata (stack_rdata)
    );

    fspa_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_taken (
        .i_clk   (i_clk),
        .i_we    (taken_we),
        .i_waddr (taken_waddr),
        .i_wdata (taken_wdata),
        .i_raddr (taken_raddr),
        .o_rdata (taken_rdata)
    );

    fspa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_free_offset),
        .i_divisor  (r_eb),
        .o_res      (div_res)
    );

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_fc        = r_fc;
        stack_we    = 1'b0;
        stack_waddr = r_init_idx;
        stack_wdata = r_init_idx;
        stack_raddr = SW'(r_fc - 1'b1);
        taken_we    = 1'b0;
        taken_waddr = r_init_idx;
        taken_wdata = 1'b0;
        taken_raddr = div_res.quo[SW-1:0];
        div_start   = 1'b0;

        case (r_state)
            S_INIT: begin
                stack_we = 1'b1;
                taken_we = 1'b1;
                if (r_init_idx == SW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_ALLOC) begin
                        n_state = (r_fc == '0) ? S_FIN : S_ARD;
                    end else if (r_eb == '0) begin
                        n_state = S_FIN;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_ARD: begin
                n_state = S_FIN;
            end
            S_DIV: begin
                if (div_res.done) begin
                    // quotient at or past SLOTS means offset past the pool end
                    if (div_res.quo >= OFF_W'(SLOTS) || div_res.rem != '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_TRD;
                    end
                end
            end
            S_TRD: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                    if (r_ok) begin
                        taken_we    = 1'b1;
                        taken_waddr = r_slot;
                        taken_wdata = (r_cmd == CMD_ALLOC);
                        if (r_cmd == CMD_ALLOC) begin
                            n_fc = r_fc - 1'b1;
                        end else begin
                            stack_we    = 1'b1;
                            stack_waddr = SW'(r_fc);
                            stack_wdata = r_slot;
                            n_fc        = r_fc + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_fc        <= FCW'(SLOTS);
            r_eb        <= ENTRY_BYTES_RST;
            r_init_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fc    <= n_fc;
            if (i_cfg_valid) begin
                r_eb <= i_cfg_data;
            end
            if (r_state == S_INIT) begin
                r_init_idx <= r_init_idx + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-command working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_cmd <= i_cmd;
                    r_off <= i_free_offset;
                    r_ok  <= 1'b0;
                    if (i_cmd == CMD_ALLOC) begin
                        r_status <= ST_EMPTY;
                    end else begin
                        r_status <= ST_RANGE;
                    end
                end
            end
            S_ARD: begin
                r_slot   <= stack_rdata;
                r_prod   <= PROD_W'(stack_rdata) * PROD_W'(r_eb);
                r_ok     <= 1'b1;
                r_status <= ST_OK;
            end
            S_DIV: begin
                if (div_res.done) begin
                    r_slot <= div_res.quo[SW-1:0];
                    if (div_res.quo >= OFF_W'(SLOTS)) begin
                        r_status <= ST_RANGE;
                    end else if (div_res.rem != '0) begin
                        r_status <= ST_ALIGN;
                    end
                end
            end
            S_TRD: begin
                if (taken_rdata && r_fc < FCW'(SLOTS)) begin
                    r_ok     <= 1'b1;
                    r_status <= ST_OK;
                end else begin
                    r_status <= ST_NOTTAKEN;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status;
            r_out_free   <= FREE_W'(n_fc);
            if (r_ok) begin
                r_out_slot   <= SLOT_NUM_W'(r_slot);
                // a freed slot's offset is the aligned offset that named it
                r_out_offset <= (r_cmd == CMD_ALLOC) ? OFF_W'(r_prod) : r_off;
            end else begin
                r_out_slot   <= '0;
                r_out_offset <= '0;
            end
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot_number = r_out_slot;
    assign o_slot_offset = r_out_offset;
    assign o_free_slots  = r_out_free;

endmodule

/* hdl/fspa_checker.sv */
module fspa_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [fspa_pkg::STATUS_W-1:0]     o_status,
    input logic [fspa_pkg::SLOT_NUM_W-1:0]   o_slot_number,
    input logic [fspa_pkg::OFF_W-1:0]        o_slot_offset,
    input logic [fspa_pkg::FREE_W-1:0]       o_free_slots
);
    import fspa_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_slot_number) && $stable(o_slot_offset) && $stable(o_free_slots))
        else $error("result changed while stalled");

    // one command in flight: input side closes after each accepted transaction
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second command accepted while one is in flight");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_slot_number == '0 && o_slot_offset == '0)
        else $error("error result carries a slot");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_free_slots == '0)
        else $error("pool empty reported with free slots left");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == ST_OK || o_status == ST_EMPTY || o_status == ST_RANGE
            || o_status == ST_ALIGN || o_status == ST_NOTTAKEN)
        else $error("undefined status code");

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (.*);
